// File: hw/rtl/ecsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ecsd_pkg;

  typedef struct packed {
    logic               mode;
    logic        [5:0]  cov_row;
    logic        [5:0]  cov_col;
    logic signed [31:0] cov_value;
    logic               new_subject;
    logic        [5:0]  obs_time;
    logic signed [31:0] residual;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] std_residual;
    logic        [30:0] chart_stat;
    logic               alarm;
    logic               skipped;
    logic        [4:0]  sprint_len;
    logic               numeric_error;
    logic               sprint_overflow;
  } out_item_t;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_OBS  = 1'b1;

  localparam int CFG_IW = 1;
  localparam int CFG_DW = 31;
  localparam logic [CFG_IW-1:0] CFG_SMOOTHING = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_LIMIT     = 1'd1;

  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [16:0] SW_RESET    = 17'd6554;
  localparam logic [30:0] LIMIT_RESET = 31'd196608;

endpackage
`default_nettype wire

// File: hw/rtl/ecsd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ecsd_in_if;
  logic               valid;
  logic               ready;
  ecsd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ecsd_out_if;
  logic                valid;
  logic                ready;
  ecsd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ewma_chart_sprint_decorrelation_core.sv
`timescale 1ns / 1ps
`default_nettype none
// EWMA control chart over decorrelated Q16.16 residuals. A covariance load
// (mode 0) is written to the covariance memory and gives no result. An
// observation with k earlier items in its sprint has its time index reduced,
// then the single 33x33 multiplier runs the inverse Cholesky row update in
// issue, multiply and accumulate steps, a bit-serial square root follows, and
// a bit-serial divider does each of the k+2 divisions. The input is not ready
// while an observation is in work; a finished result waits in the output
// register.
module ewma_chart_sprint_decorrelation_core #(
  parameter int TIME_POINTS = 64,
  parameter int MAX_SPRINT  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ecsd_in_if.sink                       in_ch,
  ecsd_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [ecsd_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ecsd_pkg::CFG_DW-1:0]   cfg_wdata
);
  import ecsd_pkg::*;

  localparam int TW  = $clog2(TIME_POINTS);
  localparam int CAW = $clog2(TIME_POINTS * TIME_POINTS);
  localparam int IW  = (MAX_SPRINT > 1) ? $clog2(MAX_SPRINT) : 1;
  localparam int CW  = $clog2(MAX_SPRINT + 1);
  localparam int UAW = (MAX_SPRINT > 1) ? $clog2(MAX_SPRINT * MAX_SPRINT) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_CTT, S_CTT2, S_ISS, S_MUL, S_ACC, S_VCHK,
    S_SQRT, S_DIVLD, S_DIV, S_DIVEND, S_EW1, S_EW2, S_EW3, S_OUT
  } state_t;
  typedef enum logic [1:0] {PH_LV, PH_VV, PH_UR, PH_ER} phase_t;
  typedef enum logic [1:0] {DST_U, DST_UKK, DST_E} dst_t;

  state_t state_r;
  phase_t ph_r;
  dst_t   dst_r;

  logic [16:0]        sw_r;
  logic [30:0]        lim_r;
  logic [5:0]         t_r;
  logic signed [31:0] r_r;
  logic               ovf_r;
  logic [CW-1:0]      k_r, i_r, j_r, count_r;
  logic signed [51:0] acc_r;
  logic signed [31:0] covtt_r;
  logic [47:0]        sx_r, sbit_r, sroot_r;
  logic [4:0]         scnt_r;
  logic [23:0]        d_r;
  logic signed [52:0] num_r;
  logic [23:0]        rem_r;
  logic [56:0]        quo_r;
  logic               neg_r;
  logic [5:0]         dcnt_r;
  logic signed [31:0] e_r;
  logic signed [65:0] prod_r, ewacc_r;
  logic [30:0]        last_r;
  logic               sig_r;
  out_item_t          pend_r, out_r;
  logic               out_valid_r;

  logic signed [31:0] lvec_r [MAX_SPRINT];
  logic signed [31:0] res_r  [MAX_SPRINT];
  logic [TW-1:0]      times_r [MAX_SPRINT];

  // covariance memory
  logic signed [31:0] cov_mem [TIME_POINTS*TIME_POINTS];
  logic signed [31:0] c_q;
  logic [CAW-1:0]     c_addr, cov_waddr;
  logic               cov_we;
  // inverse factor memory
  logic signed [31:0] u_mem [MAX_SPRINT*MAX_SPRINT];
  logic signed [31:0] u_q;
  logic [UAW-1:0]     u_raddr, u_waddr;
  logic               u_we;
  logic signed [31:0] dres;

  logic               in_xfer;
  logic [TW-1:0]      t_idx, crow;
  logic [16:0]        lam;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod, padj, qt, ssum, sadj, sst;
  logic signed [51:0] acc_nxt;
  logic signed [52:0] v;
  logic [47:0]        rb, sroot_nxt;
  logic [24:0]        trial;
  logic               ge;
  logic [30:0]        stat;
  logic signed [31:0] lv_i, res_i;
  logic [CW-1:0]      cnt_eff;
  logic               sig_eff;
  logic signed [52:0] numc;
  logic [52:0]        mag;
  out_item_t          skip_item, err_item, ew_item;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] a);
    if (a > 52'sd2147483647) return 32'sh7fffffff;
    else if (a < -52'sd2147483648) return 32'sh80000000;
    else return a[31:0];
  endfunction

  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_r;

  assign t_idx = TW'(t_r);
  assign lam   = (sw_r > ONE_Q16) ? ONE_Q16 : sw_r;
  assign lv_i  = lvec_r[i_r[IW-1:0]];
  assign res_i = res_r[i_r[IW-1:0]];

  assign cov_we = in_xfer && (in_ch.data.mode == MODE_LOAD)
                  && (32'(in_ch.data.cov_row) < TIME_POINTS)
                  && (32'(in_ch.data.cov_col) < TIME_POINTS);
  assign cov_waddr = CAW'(in_ch.data.cov_row) * CAW'(TIME_POINTS)
                     + CAW'(in_ch.data.cov_col);
  assign crow   = (state_r == S_CTT) ? t_idx : times_r[j_r[IW-1:0]];
  assign c_addr = CAW'(crow) * CAW'(TIME_POINTS) + CAW'(t_idx);

  assign u_raddr = UAW'(i_r) * UAW'(MAX_SPRINT) + UAW'(j_r);
  assign u_we    = (state_r == S_DIVEND) && (dst_r != DST_E);
  assign u_waddr = UAW'(k_r) * UAW'(MAX_SPRINT)
                   + UAW'((dst_r == DST_UKK) ? k_r : j_r);

  always_ff @(posedge clk) begin
    if (cov_we) begin
      cov_mem[cov_waddr] <= in_ch.data.cov_value;
    end
    c_q <= cov_mem[c_addr];
  end

  always_ff @(posedge clk) begin
    if (u_we) begin
      u_mem[u_waddr] <= dres;
    end
    u_q <= u_mem[u_raddr];
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_EW1: begin
        ma = $signed({16'd0, lam});
        mb = 33'(e_r);
      end
      S_EW2: begin
        ma = $signed({16'd0, ONE_Q16 - lam});
        mb = $signed({2'b0, last_r});
      end
      default: begin
        case (ph_r)
          PH_LV: begin ma = 33'(u_q); mb = 33'(c_q); end
          PH_VV: begin ma = 33'(lv_i); mb = 33'(lv_i); end
          PH_UR: begin ma = 33'(lv_i); mb = 33'(u_q); end
          PH_ER: begin ma = 33'(lv_i); mb = 33'(res_i); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
    endcase
  end

  always_comb begin
    mprod   = ma * mb;
    padj    = prod_r + (prod_r[65] ? 66'sd65535 : 66'sd0);
    qt      = padj >>> 16;
    acc_nxt = acc_r + $signed(qt[51:0]);
    v       = 53'(covtt_r) - 53'(acc_r);
    rb      = sroot_r + sbit_r;
    sroot_nxt = (sx_r >= rb) ? ((sroot_r >> 1) + sbit_r) : (sroot_r >> 1);
    trial   = {rem_r, quo_r[56]};
    ge      = (trial >= {1'b0, d_r});
    ssum    = ewacc_r + prod_r;
    sadj    = ssum + (ssum[65] ? 66'sd65535 : 66'sd0);
    sst     = sadj >>> 16;
    if (sst[65]) stat = '0;
    else if (sst > 66'sd2147483647) stat = 31'h7fffffff;
    else stat = sst[30:0];
    if (num_r > 53'sd1099511627776) numc = 53'sd1099511627776;
    else if (num_r < -53'sd1099511627776) numc = -53'sd1099511627776;
    else numc = num_r;
    mag = numc[52] ? 53'(-numc) : 53'(numc);
    if (neg_r) begin
      dres = (quo_r > 57'd2147483648) ? 32'sh80000000 : -$signed(quo_r[31:0]);
    end else begin
      dres = (quo_r > 57'd2147483647) ? 32'sh7fffffff : $signed(quo_r[31:0]);
    end
    cnt_eff = in_ch.data.new_subject ? '0 : count_r;
    sig_eff = in_ch.data.new_subject ? 1'b0 : sig_r;
    skip_item = '0;
    skip_item.skipped = 1'b1;
    err_item = '0;
    err_item.numeric_error   = 1'b1;
    err_item.sprint_overflow = ovf_r;
    ew_item = '0;
    ew_item.std_residual    = e_r;
    ew_item.chart_stat      = stat;
    ew_item.sprint_overflow = ovf_r;
    ew_item.alarm           = (stat >= lim_r);
    if (stat >= lim_r || stat != '0) ew_item.sprint_len = 5'(k_r + CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      last_r      <= '0;
      sig_r       <= 1'b0;
      sw_r        <= SW_RESET;
      lim_r       <= LIMIT_RESET;
      ph_r        <= PH_LV;
      dst_r       <= DST_U;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SMOOTHING: sw_r <= cfg_wdata[16:0];
          CFG_LIMIT:     lim_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer && in_ch.data.mode == MODE_OBS) begin
            if (in_ch.data.new_subject) begin
              count_r <= '0;
              last_r  <= '0;
              sig_r   <= 1'b0;
            end
            if (sig_eff) begin
              pend_r  <= skip_item;
              state_r <= S_OUT;
            end else begin
              t_r     <= in_ch.data.obs_time;
              r_r     <= in_ch.data.residual;
              ovf_r   <= (32'(cnt_eff) >= MAX_SPRINT);
              k_r     <= (32'(cnt_eff) >= MAX_SPRINT) ? '0 : cnt_eff;
              state_r <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (32'(t_r) >= TIME_POINTS) t_r <= t_r - 6'(TIME_POINTS);
          else state_r <= S_CTT;
        end
        S_CTT: state_r <= S_CTT2;
        S_CTT2: begin
          covtt_r <= c_q;
          acc_r   <= '0;
          i_r     <= '0;
          j_r     <= '0;
          ph_r    <= PH_LV;
          state_r <= (k_r == '0) ? S_VCHK : S_ISS;
        end
        S_ISS: state_r <= S_MUL;
        S_MUL: begin
          prod_r  <= mprod;
          state_r <= S_ACC;
        end
        S_ACC: begin
          case (ph_r)
            PH_LV: begin
              state_r <= S_ISS;
              if (j_r == i_r) begin
                lvec_r[i_r[IW-1:0]] <= sat32(acc_nxt);
                acc_r <= '0;
                j_r   <= '0;
                if (i_r + CW'(1) == k_r) begin
                  i_r  <= '0;
                  ph_r <= PH_VV;
                end else begin
                  i_r <= i_r + CW'(1);
                end
              end else begin
                acc_r <= acc_nxt;
                j_r   <= j_r + CW'(1);
              end
            end
            PH_VV: begin
              acc_r <= acc_nxt;
              if (i_r + CW'(1) == k_r) begin
                state_r <= S_VCHK;
              end else begin
                i_r     <= i_r + CW'(1);
                state_r <= S_ISS;
              end
            end
            PH_UR: begin
              acc_r <= acc_nxt;
              if (i_r + CW'(1) == k_r) begin
                num_r   <= -53'(acc_nxt);
                dst_r   <= DST_U;
                state_r <= S_DIVLD;
              end else begin
                i_r     <= i_r + CW'(1);
                state_r <= S_ISS;
              end
            end
            PH_ER: begin
              acc_r <= acc_nxt;
              if (i_r + CW'(1) == k_r) begin
                num_r   <= 53'(r_r) - 53'(acc_nxt);
                dst_r   <= DST_E;
                state_r <= S_DIVLD;
              end else begin
                i_r     <= i_r + CW'(1);
                state_r <= S_ISS;
              end
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_VCHK: begin
          if (v[52] || v == '0) begin
            count_r <= '0;
            last_r  <= '0;
            pend_r  <= err_item;
            state_r <= S_OUT;
          end else begin
            sx_r    <= {1'b0, v[30:0], 16'b0};
            sbit_r  <= 48'h1 << 46;
            sroot_r <= '0;
            scnt_r  <= 5'd23;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sx_r >= rb) sx_r <= sx_r - rb;
          sroot_r <= sroot_nxt;
          sbit_r  <= sbit_r >> 2;
          scnt_r  <= scnt_r - 5'd1;
          if (scnt_r == '0) begin
            d_r   <= sroot_nxt[23:0];
            acc_r <= '0;
            i_r   <= '0;
            j_r   <= '0;
            if (k_r == '0) begin
              num_r   <= 53'sd65536;
              dst_r   <= DST_UKK;
              state_r <= S_DIVLD;
            end else begin
              ph_r    <= PH_UR;
              state_r <= S_ISS;
            end
          end
        end
        S_DIVLD: begin
          neg_r   <= numc[52];
          quo_r   <= {mag[40:0], 16'b0};
          rem_r   <= '0;
          dcnt_r  <= 6'd56;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= ge ? 24'(trial - {1'b0, d_r}) : trial[23:0];
          quo_r  <= {quo_r[55:0], ge};
          dcnt_r <= dcnt_r - 6'd1;
          if (dcnt_r == '0) state_r <= S_DIVEND;
        end
        S_DIVEND: begin
          acc_r <= '0;
          case (dst_r)
            DST_U: begin
              if (j_r + CW'(1) == k_r) begin
                num_r   <= 53'sd65536;
                dst_r   <= DST_UKK;
                state_r <= S_DIVLD;
              end else begin
                j_r     <= j_r + CW'(1);
                i_r     <= j_r + CW'(1);
                state_r <= S_ISS;
              end
            end
            DST_UKK: begin
              if (k_r == '0) begin
                num_r   <= 53'(r_r);
                dst_r   <= DST_E;
                state_r <= S_DIVLD;
              end else begin
                i_r     <= '0;
                ph_r    <= PH_ER;
                state_r <= S_ISS;
              end
            end
            default: begin
              e_r     <= dres;
              state_r <= S_EW1;
            end
          endcase
        end
        S_EW1: begin
          prod_r  <= mprod;
          state_r <= S_EW2;
        end
        S_EW2: begin
          ewacc_r <= prod_r;
          prod_r  <= mprod;
          state_r <= S_EW3;
        end
        S_EW3: begin
          last_r <= stat;
          pend_r <= ew_item;
          if (stat >= lim_r) begin
            sig_r <= 1'b1;
          end
          if (stat >= lim_r || stat != '0) begin
            times_r[k_r[IW-1:0]] <= t_idx;
            res_r[k_r[IW-1:0]]   <= e_r;
            count_r              <= k_r + CW'(1);
          end else begin
            count_r <= '0;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r   <= pend_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
